>>> src/rtm_pkg.sv
// Shared types and constants for the region table merge-insert block.
package rtm_pkg;

  localparam int ADDR_W = 64;
  localparam int KIND_W = 3;
  localparam int USED_W = 6;

  localparam logic [KIND_W-1:0] KIND_USABLE = 3'd0;

  // Shared adder operations
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic [KIND_W-1:0] kind;
  } entry_t;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } alu_req_t;

endpackage

>>> src/rtm_if.sv
// Valid/ready channel interfaces for region items and merge results.
interface rtm_in_if import rtm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] region_base;
  logic [ADDR_W-1:0] region_length;
  logic [KIND_W-1:0] region_kind;

  modport source (output valid, region_base, region_length, region_kind, input ready);
  modport sink (input valid, region_base, region_length, region_kind, output ready);
endinterface

interface rtm_out_if import rtm_pkg::*;;
  logic              valid;
  logic              ready;
  logic              status;
  logic [ADDR_W-1:0] merged_base;
  logic [ADDR_W-1:0] merged_length;
  logic [USED_W-1:0] entries_used;
  logic [ADDR_W-1:0] total_bytes;
  logic [ADDR_W-1:0] usable_bytes;

  modport source (output valid, status, merged_base, merged_length, entries_used,
                  total_bytes, usable_bytes, input ready);
  modport sink (input valid, status, merged_base, merged_length, entries_used,
                total_bytes, usable_bytes, output ready);
endinterface

>>> src/rtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/rtm_alu.sv
// Shared 64-bit add/subtract unit used for region ends and merged sizes.
module rtm_alu import rtm_pkg::*; (
  input  alu_req_t          req,
  output logic [ADDR_W-1:0] y
);

  always_comb begin
    case (req.op)
      ALU_ADD: y = req.a + req.b;
      ALU_SUB: y = req.a - req.b;
      default: y = '0;
    endcase
  end

endmodule

>>> src/region_table_merge_insert.sv
// Top level: region table with merge-on-insert, sequencer and result register.
//
// Usage:
//   in_ch  : one region (base, length, kind) per transfer. Ready is high only
//            while the sequencer is idle; one region is processed at a time.
//   out_ch : one result per region: status (1 = table full, nothing stored),
//            merged base/length, entry count and the total/usable byte sums.
// Sequence: the scan walks the stored entries through the table RAM's single
//   registered read port, one entry per cycle while no entry is absorbed. An
//   absorbed entry is replaced by moving the last entry into its slot, which is
//   then read and checked again. The merged region is then sized and appended
//   (unless the table is full), and the next region can be taken once the
//   result has been loaded into the output register.
// Reset (rst_n low, synchronous) empties the table and clears both sums;
//   table contents are not cleared, entries beyond the count are never read.
// Stall: the result waits in the output register. A new region may be taken
//   meanwhile; its own result waits inside until the register frees up.
module region_table_merge_insert import rtm_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  rtm_in_if.sink    in_ch,
  rtm_out_if.source out_ch
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_MOVE = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_SIZE = 3'd4;
  localparam logic [2:0] S_APP  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [ADDR_W-1:0] total_r, total_nxt;
  logic [ADDR_W-1:0] usable_r, usable_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] end_r, end_nxt;
  logic [ADDR_W-1:0] lo_r, lo_nxt;
  logic [ADDR_W-1:0] hi_r, hi_nxt;
  logic [ADDR_W-1:0] sz_r, sz_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic              full_r, full_nxt;

  logic              out_valid_r;
  logic              out_status_r;
  logic [ADDR_W-1:0] out_base_r;
  logic [ADDR_W-1:0] out_len_r;
  logic [USED_W-1:0] out_used_r;
  logic [ADDR_W-1:0] out_total_r;
  logic [ADDR_W-1:0] out_usable_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  entry_t            ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t            rd_entry;

  alu_req_t          alu_req;
  logic [ADDR_W-1:0] alu_y;

  logic              in_xfer;
  logic              out_free;
  logic              hit;
  logic [CW-1:0]     idx_inc;
  logic [CW-1:0]     last;
  logic [CW+USED_W-1:0] cnt_ext;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign rd_entry = entry_t'(ram_rdata);
  assign idx_inc  = idx_r + CW'(1);
  assign last     = cnt_r - CW'(1);
  assign cnt_ext  = {{USED_W{1'b0}}, cnt_r};

  rtm_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rtm_alu u_alu (
    .req(alu_req),
    .y  (alu_y)
  );

  // Shared adder operand select
  always_comb begin
    alu_req = '{op: ALU_ADD, a: '0, b: '0};
    case (state_r)
      S_IDLE: alu_req = '{op: ALU_ADD, a: in_ch.region_base, b: in_ch.region_length};
      S_CHK:  alu_req = '{op: ALU_ADD, a: rd_entry.start, b: rd_entry.size};
      S_SIZE: alu_req = '{op: ALU_SUB, a: hi_r, b: lo_r};
      default: alu_req = '{op: ALU_ADD, a: '0, b: '0};
    endcase
  end

  // Absorb test: same kind, entry end at or past base, entry start at or below end
  assign hit = (rd_entry.kind == kind_r) && (alu_y >= base_r) && (rd_entry.start <= end_r);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    total_nxt  = total_r;
    usable_nxt = usable_r;
    base_nxt   = base_r;
    end_nxt    = end_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    sz_nxt     = sz_r;
    kind_nxt   = kind_r;
    full_nxt   = full_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r[AW-1:0];
    ram_wdata  = rd_entry;
    ram_raddr  = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        ram_raddr = '0;
        if (in_xfer) begin
          base_nxt = in_ch.region_base;
          end_nxt  = alu_y;
          lo_nxt   = in_ch.region_base;
          hi_nxt   = alu_y;
          kind_nxt = in_ch.region_kind;
          idx_nxt  = '0;
          state_nxt = (cnt_r == '0) ? S_SIZE : S_CHK;
        end
      end
      S_CHK: begin
        if (hit) begin
          if (rd_entry.start < lo_r) begin
            lo_nxt = rd_entry.start;
          end
          if (alu_y > hi_r) begin
            hi_nxt = alu_y;
          end
          total_nxt = total_r - rd_entry.size;
          if (kind_r == KIND_USABLE) begin
            usable_nxt = usable_r - rd_entry.size;
          end
          cnt_nxt = last;
          if (idx_r == last) begin
            state_nxt = S_SIZE;
          end else begin
            ram_raddr = last[AW-1:0];
            state_nxt = S_MOVE;
          end
        end else if (idx_inc < cnt_r) begin
          idx_nxt   = idx_inc;
          ram_raddr = idx_inc[AW-1:0];
        end else begin
          state_nxt = S_SIZE;
        end
      end
      S_MOVE: begin
        // last entry fills the absorbed slot
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = rd_entry;
        state_nxt = S_RD;
      end
      S_RD: begin
        ram_raddr = idx_r[AW-1:0];
        state_nxt = S_CHK;
      end
      S_SIZE: begin
        sz_nxt    = alu_y;
        state_nxt = S_APP;
      end
      S_APP: begin
        if (cnt_r == CW'(TABLE_DEPTH)) begin
          full_nxt = 1'b1;
        end else begin
          full_nxt  = 1'b0;
          ram_we    = 1'b1;
          ram_waddr = cnt_r[AW-1:0];
          ram_wdata = '{start: lo_r, size: sz_r, kind: kind_r};
          cnt_nxt   = cnt_r + CW'(1);
          total_nxt = total_r + sz_r;
          if (kind_r == KIND_USABLE) begin
            usable_nxt = usable_r + sz_r;
          end
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      total_r     <= '0;
      usable_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      total_r  <= total_nxt;
      usable_r <= usable_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    base_r <= base_nxt;
    end_r  <= end_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    sz_r   <= sz_nxt;
    kind_r <= kind_nxt;
    full_r <= full_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_status_r <= full_r;
      out_base_r   <= full_r ? '0 : lo_r;
      out_len_r    <= full_r ? '0 : sz_r;
      out_used_r   <= cnt_ext[USED_W-1:0];
      out_total_r  <= total_r;
      out_usable_r <= usable_r;
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.merged_base   = out_base_r;
  assign out_ch.merged_length = out_len_r;
  assign out_ch.entries_used  = out_used_r;
  assign out_ch.total_bytes   = out_total_r;
  assign out_ch.usable_bytes  = out_usable_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (idx_r < cnt_r))
    else $error("scan index past entry count");

  a_append_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APP && cnt_r != CW'(TABLE_DEPTH)) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("append did not advance entry count");
`endif

endmodule
